FILE: rtl/sswt_pkg.sv
// Shared types, constants and the layout table for the viewport tiler.
`timescale 1ns / 1ps
package sswt_pkg;

	// Field and register widths
	localparam int DimW     = 16;
	localparam int CountW   = 5;
	localparam int IdxW     = 4;
	localparam int MaxViews = 16;
	// Rows and columns of a layout never exceed four
	localparam int CntW     = 3;
	localparam int CfgIdxW  = 2;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		RegWindowWidth     = 2'd0,
		RegWindowHeight    = 2'd1,
		RegHorizontalSplit = 2'd2
	} cfg_reg_t;

	// Shape of one layout: row count, the two column counts and how many
	// leading rows take the smaller one
	typedef struct packed {
		logic [CntW-1:0] rows;
		logic [CntW-1:0] min_cols;
		logic [CntW-1:0] max_cols;
		logic [CntW-1:0] min_rows;
	} layout_t;

	// Layout shape for a saturated view count of one to sixteen
	function automatic layout_t layout_lookup(input logic [CountW-1:0] n);
		layout_t l;
		case (n)
			5'd1:    l = '{3'd1, 3'd1, 3'd1, 3'd0};
			5'd2:    l = '{3'd2, 3'd1, 3'd1, 3'd0};
			5'd3:    l = '{3'd2, 3'd1, 3'd2, 3'd1};
			5'd4:    l = '{3'd2, 3'd2, 3'd2, 3'd0};
			5'd5:    l = '{3'd3, 3'd1, 3'd2, 3'd1};
			5'd6:    l = '{3'd3, 3'd2, 3'd2, 3'd0};
			5'd7:    l = '{3'd3, 3'd2, 3'd3, 3'd2};
			5'd8:    l = '{3'd3, 3'd2, 3'd3, 3'd1};
			5'd9:    l = '{3'd3, 3'd3, 3'd3, 3'd0};
			5'd10:   l = '{3'd4, 3'd2, 3'd3, 3'd2};
			5'd11:   l = '{3'd4, 3'd2, 3'd3, 3'd1};
			5'd12:   l = '{3'd4, 3'd3, 3'd3, 3'd0};
			5'd13:   l = '{3'd4, 3'd3, 3'd4, 3'd3};
			5'd14:   l = '{3'd4, 3'd3, 3'd4, 3'd2};
			5'd15:   l = '{3'd4, 3'd3, 3'd4, 3'd1};
			5'd16:   l = '{3'd4, 3'd4, 3'd4, 3'd0};
			default: l = '{3'd1, 3'd1, 3'd1, 3'd0};
		endcase
		return l;
	endfunction

endpackage

FILE: rtl/sswt_div.sv
// Iterative restoring divider: one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps
module sswt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sswt_pkg::DimW-1:0] dividend,
	input  logic [sswt_pkg::CntW-1:0] divisor,
	output logic                      done,
	output logic [sswt_pkg::DimW-1:0] quotient
);
	import sswt_pkg::*;

	localparam int StepW = $clog2(DimW);

	logic                 busy_q;
	logic                 done_q;
	logic [StepW-1:0]     step_q;
	logic [DimW-1:0]      quo_q;
	logic [CntW-2:0]      rem_q;
	logic [CntW-1:0]      dsr_q;
	logic [CntW-1:0]      trial;
	logic                 fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DimW-1]};
	assign fits  = (trial >= dsr_q);

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(DimW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend and quotient share the shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DimW-2:0], fits};
			rem_q <= fits ? (CntW-1)'(trial - dsr_q) : trial[CntW-2:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (divisor != '0))
		else $error("divider started with a zero divisor");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

	a_div_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

FILE: rtl/split_screen_viewport_tiler.sv
// Split-screen viewport tiler: sequencer, layout registers and result register.
//
// A request carries view_count on view_valid/view_stall; one transaction is taken
// while the block is idle, and view_stall stays high until the last viewport of the
// layout has been taken. Each viewport leaves on tile_valid/tile_stall with its index,
// origin, size and last_view. Counts above sixteen are treated as sixteen; a zero
// count or an unsized window gives no transaction on the result side.
// Window size and split direction are written on cfg_wr_en/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself does not
// enforce. Unknown indexes are dropped. One shared 16-step divider does all the
// divisions. The row share takes one division, each row one more for its column
// share, and each viewport is then loaded into the result register in ST_EMIT and
// held there in ST_HOLD. A stall on tile_stall holds the result register and freezes
// the sequence; nothing is dropped. Reset clears the sequencer, sets the window to
// unsized and selects horizontal division.
`timescale 1ns / 1ps
module split_screen_viewport_tiler (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         cfg_wr_en,
	input  logic [sswt_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sswt_pkg::DimW-1:0]    cfg_data,
	// request channel
	input  logic                         view_valid,
	output logic                         view_stall,
	input  logic [sswt_pkg::CountW-1:0]  view_count,
	// result channel
	output logic                         tile_valid,
	input  logic                         tile_stall,
	output logic [sswt_pkg::IdxW-1:0]    view_index,
	output logic [sswt_pkg::DimW-1:0]    origin_x,
	output logic [sswt_pkg::DimW-1:0]    origin_y,
	output logic [sswt_pkg::DimW-1:0]    span_width,
	output logic [sswt_pkg::DimW-1:0]    span_height,
	output logic                         last_view
);
	import sswt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_START,
		ST_ROW_WAIT,
		ST_COL_START,
		ST_COL_WAIT,
		ST_EMIT,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic [DimW-1:0]   window_width_q;
	logic [DimW-1:0]   window_height_q;
	logic              horizontal_split_q;

	logic [CountW-1:0] n_q;
	layout_t           lay_q;
	logic [CntW-1:0]   row_q;
	logic [CntW-1:0]   col_q;
	logic [IdxW-1:0]   k_q;
	logic [DimW-1:0]   done_a_q;
	logic [DimW-1:0]   done_b_q;
	logic [DimW-1:0]   row_share_q;
	logic [DimW-1:0]   col_share_q;

	logic              div_start_q;
	logic [DimW-1:0]   div_num_q;
	logic [CntW-1:0]   div_dsr_q;
	logic              div_done;
	logic [DimW-1:0]   div_quo;

	logic              tile_valid_q;
	logic [IdxW-1:0]   view_index_q;
	logic [DimW-1:0]   origin_x_q;
	logic [DimW-1:0]   origin_y_q;
	logic [DimW-1:0]   span_width_q;
	logic [DimW-1:0]   span_height_q;
	logic              last_view_q;

	logic              in_accept;
	logic              out_accept;
	logic [CountW-1:0] n_sat;
	logic [CntW-1:0]   cols;
	logic              last_col;
	logic              last_row;
	logic              last_k;
	logic [DimW-1:0]   axis_a;
	logic [DimW-1:0]   axis_b;
	logic [DimW-1:0]   span_a;
	logic [DimW-1:0]   span_b;
	logic [DimW-1:0]   w_calc;
	logic [DimW-1:0]   h_calc;
	logic [DimW-1:0]   x_calc;
	logic [DimW-1:0]   y_base;
	logic [DimW-1:0]   y_calc;

	// Shared divider
	sswt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (div_dsr_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_accept  = view_valid && !view_stall;
	assign out_accept = tile_valid_q && !tile_stall;
	assign n_sat      = (view_count > CountW'(MaxViews)) ? CountW'(MaxViews) : view_count;

	// Axis a runs along a row of viewports, axis b across the rows
	assign axis_a = horizontal_split_q ? window_width_q  : window_height_q;
	assign axis_b = horizontal_split_q ? window_height_q : window_width_q;

	// Position within the layout
	assign cols     = (row_q < lay_q.min_rows) ? lay_q.min_cols : lay_q.max_cols;
	assign last_col = ((col_q + 1'b1) == cols);
	assign last_row = ((row_q + 1'b1) == lay_q.rows);
	assign last_k   = (({1'b0, k_q} + 1'b1) == n_q);

	// Size and place the current viewport; last column and row take the leftover
	assign span_a = last_col ? (axis_a - done_a_q) : col_share_q;
	assign span_b = last_row ? (axis_b - done_b_q) : row_share_q;
	assign w_calc = horizontal_split_q ? span_a   : span_b;
	assign h_calc = horizontal_split_q ? span_b   : span_a;
	assign x_calc = horizontal_split_q ? done_a_q : done_b_q;
	assign y_base = horizontal_split_q ? done_b_q : done_a_q;
	assign y_calc = window_height_q - (y_base + h_calc);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q     <= '0;
			window_height_q    <= '0;
			horizontal_split_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				RegWindowWidth:     window_width_q     <= cfg_data;
				RegWindowHeight:    window_height_q    <= cfg_data;
				RegHorizontalSplit: horizontal_split_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_start_q   <= 1'b0;
			div_num_q     <= '0;
			div_dsr_q     <= '0;
			row_share_q   <= '0;
			col_share_q   <= '0;
			tile_valid_q  <= 1'b0;
			view_index_q  <= '0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			span_width_q  <= '0;
			span_height_q <= '0;
			last_view_q   <= 1'b0;
			n_q           <= '0;
			lay_q         <= '0;
			row_q         <= '0;
			col_q         <= '0;
			k_q           <= '0;
			done_a_q      <= '0;
			done_b_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (view_count != '0) && (window_width_q != '0)
					    && (window_height_q != '0)) begin
						n_q      <= n_sat;
						lay_q    <= layout_lookup(n_sat);
						row_q    <= '0;
						col_q    <= '0;
						k_q      <= '0;
						done_a_q <= '0;
						done_b_q <= '0;
						state_q  <= ST_ROW_START;
					end
				end
				ST_ROW_START: begin
					div_start_q <= 1'b1;
					div_num_q   <= axis_b;
					div_dsr_q   <= lay_q.rows;
					state_q     <= ST_ROW_WAIT;
				end
				ST_ROW_WAIT: begin
					if (div_done) begin
						row_share_q <= div_quo;
						state_q     <= ST_COL_START;
					end
				end
				ST_COL_START: begin
					div_start_q <= 1'b1;
					div_num_q   <= axis_a;
					div_dsr_q   <= cols;
					state_q     <= ST_COL_WAIT;
				end
				ST_COL_WAIT: begin
					if (div_done) begin
						col_share_q <= div_quo;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					tile_valid_q  <= 1'b1;
					view_index_q  <= k_q;
					origin_x_q    <= x_calc;
					origin_y_q    <= y_calc;
					span_width_q  <= w_calc;
					span_height_q <= h_calc;
					last_view_q   <= last_k;
					state_q       <= ST_HOLD;
				end
				ST_HOLD: begin
					// Advance once the receiver takes the transaction
					if (out_accept) begin
						tile_valid_q <= 1'b0;
						k_q          <= k_q + 1'b1;
						if (last_k) begin
							state_q <= ST_IDLE;
						end else if (last_col) begin
							row_q    <= row_q + 1'b1;
							col_q    <= '0;
							done_a_q <= '0;
							done_b_q <= done_b_q + row_share_q;
							state_q  <= ST_COL_START;
						end else begin
							col_q    <= col_q + 1'b1;
							done_a_q <= done_a_q + span_a;
							state_q  <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign view_stall  = (state_q != ST_IDLE);
	assign tile_valid  = tile_valid_q;
	assign view_index  = view_index_q;
	assign origin_x    = origin_x_q;
	assign origin_y    = origin_y_q;
	assign span_width  = span_width_q;
	assign span_height = span_height_q;
	assign last_view   = last_view_q;

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!view_stall |-> !tile_valid_q)
		else $error("request side open while a result is pending");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid_q |-> ({1'b0, view_index_q} < n_q))
		else $error("viewport index beyond the requested count");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && last_view_q) |=> (!tile_valid_q && !view_stall))
		else $error("layout did not close after its last viewport");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_ROW_WAIT) || (state_q == ST_COL_WAIT)))
		else $error("division finished outside a wait state");

endmodule
